/* hdl/can_id_hit_counter_assert.svh */
// Assertion macros for the CAN identifier hit counter.
// Included by RTL files that carry concurrent assertions; no other dependencies.
`ifndef CAN_ID_HIT_COUNTER_ASSERT_SVH
`define CAN_ID_HIT_COUNTER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CIHC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cihc assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CIHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cihc assertion failed");

`endif

/* hdl/cihc_pkg.sv */
// Shared types and constants for the CAN identifier hit counter.
// No dependencies; imported by the controller, datapath and top level.
package cihc_pkg;

  localparam int unsigned FRAME_ID_W = 29;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned PAIRS_W    = 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // One table entry as stored in the memory
  typedef struct packed {
    logic [FRAME_ID_W-1:0] ident;
    logic [CHAN_W-1:0]     chan;
    logic [COUNT_W-1:0]    hits;
  } entry_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;         // capture the incoming item, restart the scan
    logic scan;         // step the table read
    logic commit_hit;   // update the matched entry and report
    logic commit_miss;  // append (or drop) and report
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic hit;   // compared entry matches the key
    logic miss;  // last filled entry compared without a match, or table empty
  } sts_t;

endpackage

/* hdl/cihc_ctrl.sv */
// Controller state machine for the CAN identifier hit counter.
// Depends on cihc_pkg; drives the datapath through cmd_t, watches sts_t.
module cihc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output cihc_pkg::cmd_t cmd,
  input  cihc_pkg::sts_t sts
);
  import cihc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          cmd.commit_hit = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (sts.miss) begin
          cmd.commit_miss = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/cihc_datapath.sv */
// Datapath for the CAN identifier hit counter: entry memory, scan pointer,
// compare, counters and result registers. Depends on cihc_pkg and the assert header.
`include "can_id_hit_counter_assert.svh"

module cihc_datapath #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [cihc_pkg::FRAME_ID_W-1:0] in_frame_id,
  input  logic [cihc_pkg::CHAN_W-1:0]     in_bus_channel,
  input  cihc_pkg::cmd_t                  cmd,
  output cihc_pkg::sts_t                  sts,
  output logic                            out_valid,
  output logic [cihc_pkg::SLOT_W-1:0]     out_slot_index,
  output logic [cihc_pkg::COUNT_W-1:0]    out_hit_count,
  output logic                            out_is_new_entry,
  output logic                            out_table_full_drop,
  output logic [cihc_pkg::PAIRS_W-1:0]    out_distinct_pairs,
  output logic [cihc_pkg::COUNT_W-1:0]    out_total_frames
);
  import cihc_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  entry_t mem [TABLE_ENTRIES];

  logic [FRAME_ID_W-1:0] key_id_r;
  logic [CHAN_W-1:0]     key_ch_r;
  logic [CW-1:0]         rd_idx_r;
  logic [IW-1:0]         cmp_idx_r;
  logic                  cmp_valid_r;
  entry_t                rd_data_r;
  logic [CW-1:0]         used_r;
  logic [COUNT_W-1:0]    total_r;

  logic                  out_valid_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [COUNT_W-1:0]    out_hits_r;
  logic                  out_new_r;
  logic                  out_drop_r;
  logic [PAIRS_W-1:0]    out_pairs_r;
  logic [COUNT_W-1:0]    out_total_r;

  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic                  match;
  logic                  last_cmp;
  logic                  full;
  logic [COUNT_W-1:0]    hits_inc;
  logic [COUNT_W-1:0]    total_inc;
  logic [CW-1:0]         used_inc;

  // Scan control and compare
  assign rd_en     = cmd.scan && (rd_idx_r < used_r);
  assign rd_addr   = rd_idx_r[IW-1:0];
  assign match     = cmp_valid_r && (rd_data_r.ident == key_id_r) &&
                     (rd_data_r.chan == key_ch_r);
  assign last_cmp  = cmp_valid_r && (CW'(cmp_idx_r) == (used_r - CW'(1)));
  assign full      = (used_r == CW'(TABLE_ENTRIES));
  assign hits_inc  = (rd_data_r.hits == COUNT_MAX) ? rd_data_r.hits
                                                   : rd_data_r.hits + COUNT_W'(1);
  assign total_inc = (total_r == COUNT_MAX) ? total_r : total_r + COUNT_W'(1);
  assign used_inc  = used_r + CW'(1);

  assign sts.hit  = match;
  assign sts.miss = !match && ((used_r == '0) || last_cmp);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r    <= '0;
      cmp_valid_r <= 1'b0;
      used_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit_hit || cmd.commit_miss;
      if (cmd.load) begin
        rd_idx_r    <= '0;
        cmp_valid_r <= 1'b0;
      end else if (cmd.scan) begin
        cmp_valid_r <= rd_en;
        if (rd_en) begin
          rd_idx_r <= rd_idx_r + CW'(1);
        end
      end
      if (cmd.commit_miss && !full) begin
        used_r <= used_inc;
      end
      if (cmd.commit_hit || cmd.commit_miss) begin
        total_r <= total_inc;
      end
    end
  end

  // Key capture and entry memory
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_id_r <= in_frame_id;
      key_ch_r <= in_bus_channel;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      cmp_idx_r <= rd_addr;
    end
    if (cmd.commit_hit) begin
      mem[cmp_idx_r] <= '{ident: key_id_r, chan: key_ch_r, hits: hits_inc};
    end else if (cmd.commit_miss && !full) begin
      mem[used_r[IW-1:0]] <= '{ident: key_id_r, chan: key_ch_r, hits: COUNT_W'(1)};
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.commit_hit) begin
      out_slot_r  <= SLOT_W'(cmp_idx_r);
      out_hits_r  <= hits_inc;
      out_new_r   <= 1'b0;
      out_drop_r  <= 1'b0;
      out_pairs_r <= PAIRS_W'(used_r);
      out_total_r <= total_inc;
    end else if (cmd.commit_miss) begin
      if (full) begin
        out_slot_r  <= '0;
        out_hits_r  <= '0;
        out_new_r   <= 1'b0;
        out_drop_r  <= 1'b1;
        out_pairs_r <= PAIRS_W'(used_r);
      end else begin
        out_slot_r  <= SLOT_W'(used_r);
        out_hits_r  <= COUNT_W'(1);
        out_new_r   <= 1'b1;
        out_drop_r  <= 1'b0;
        out_pairs_r <= PAIRS_W'(used_inc);
      end
      out_total_r <= total_inc;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_slot_index      = out_slot_r;
  assign out_hit_count       = out_hits_r;
  assign out_is_new_entry    = out_new_r;
  assign out_table_full_drop = out_drop_r;
  assign out_distinct_pairs  = out_pairs_r;
  assign out_total_frames    = out_total_r;

  // Checks
  `CIHC_ASSERT_NOW(a_used_bound, clk, rst_n, 1'b1, used_r <= CW'(TABLE_ENTRIES))
  `CIHC_ASSERT_NEXT(a_append_grows, clk, rst_n, cmd.commit_miss && !full, used_r == $past(used_r) + CW'(1))
  `CIHC_ASSERT_NEXT(a_hit_reports, clk, rst_n, cmd.commit_hit, out_valid_r && !out_new_r && !out_drop_r)
  `CIHC_ASSERT_NOW(a_kept_nonzero, clk, rst_n, out_valid_r && !out_drop_r, out_hits_r != '0)

endmodule

/* hdl/can_id_hit_counter.sv */
// Top level of the CAN identifier hit counter.
// Depends on cihc_pkg, cihc_ctrl and cihc_datapath.
//
// Counts received CAN frames per (identifier, channel) pair.
// Input: present in_frame_id and in_bus_channel with start high; the item is
// taken at a rising edge where start is high and busy is low.
// Output: out_valid is high for exactly one cycle with the result fields; the
// receiver must take it then, it cannot stall the block.
// Search: filled entries are read from a one-port entry memory one per cycle
// in insertion order. A match at entry k reports once entries 0 to k are
// compared; a new pair reports once all filled entries are compared, or with
// no read on an empty table. A new item is not taken until the last reports,
// so search time grows with the fill count. busy drops as the result is
// registered, so the next item can be taken while out_valid is shown.
// A new pair on a full table is dropped with table_full_drop set.
// Reset clears the fill count and frame total; entry memory needs no clearing
// since only filled entries are ever read.
module can_id_hit_counter #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [cihc_pkg::FRAME_ID_W-1:0] in_frame_id,
  input  logic [cihc_pkg::CHAN_W-1:0]     in_bus_channel,
  output logic                            out_valid,
  output logic [cihc_pkg::SLOT_W-1:0]     out_slot_index,
  output logic [cihc_pkg::COUNT_W-1:0]    out_hit_count,
  output logic                            out_is_new_entry,
  output logic                            out_table_full_drop,
  output logic [cihc_pkg::PAIRS_W-1:0]    out_distinct_pairs,
  output logic [cihc_pkg::COUNT_W-1:0]    out_total_frames
);
  import cihc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  cihc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // Table, counters and result registers
  cihc_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_frame_id         (in_frame_id),
    .in_bus_channel      (in_bus_channel),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_slot_index      (out_slot_index),
    .out_hit_count       (out_hit_count),
    .out_is_new_entry    (out_is_new_entry),
    .out_table_full_drop (out_table_full_drop),
    .out_distinct_pairs  (out_distinct_pairs),
    .out_total_frames    (out_total_frames)
  );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for can_id_hit_counter: random and directed CAN frames.
// Depends on cihc_pkg and the can_id_hit_counter RTL; the result predictor lives here.

module testbench;
  import cihc_pkg::*;

  localparam int unsigned TABLE_DEPTH = 256;
  // cycles without any handshake before the run is declared hung
  localparam int unsigned STALL_LIMIT = 4 * (TABLE_DEPTH + 16);

  // Expected report for one frame
  typedef struct {
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] hits;
    logic               is_new;
    logic               drop;
    logic [PAIRS_W-1:0] pairs;
    logic [COUNT_W-1:0] total;
  } frame_report_t;

  // Histogram predictor plus the queue of reports still owed by the block
  class frame_histogram;
    logic [FRAME_ID_W-1:0] slot_ident[TABLE_DEPTH];
    logic [CHAN_W-1:0]     slot_chan[TABLE_DEPTH];
    logic [COUNT_W-1:0]    slot_hits[TABLE_DEPTH];
    int unsigned           fill_level;
    logic [COUNT_W-1:0]    frame_count;
    frame_report_t         owed_reports[$];
    int unsigned           error_count;
    int unsigned           new_pairs;
    int unsigned           repeat_hits;
    int unsigned           dropped;
    int unsigned           reports_seen;

    function new();
      fill_level  = 0;
      frame_count = '0;
      error_count = 0;
      new_pairs   = 0;
      repeat_hits = 0;
      dropped     = 0;
      reports_seen = 0;
    endfunction

    // Accepted frame: search in insertion order, update and queue the report
    function void record_frame(logic [FRAME_ID_W-1:0] ident, logic [CHAN_W-1:0] chan);
      frame_report_t rep;
      bit found;
      rep = '{default: '0};
      found = 0;
      if (frame_count != COUNT_MAX) frame_count = frame_count + 1;
      for (int k = 0; k < fill_level; k++) begin
        if (!found && slot_ident[k] == ident && slot_chan[k] == chan) begin
          if (slot_hits[k] != COUNT_MAX) slot_hits[k] = slot_hits[k] + 1;
          rep.slot = k[SLOT_W-1:0];
          rep.hits = slot_hits[k];
          found = 1;
          repeat_hits++;
        end
      end
      if (!found) begin
        if (fill_level < TABLE_DEPTH) begin
          slot_ident[fill_level] = ident;
          slot_chan[fill_level]  = chan;
          slot_hits[fill_level]  = 1;
          rep.slot   = fill_level[SLOT_W-1:0];
          rep.hits   = 1;
          rep.is_new = 1'b1;
          fill_level++;
          new_pairs++;
        end else begin
          // new pair on a full table: dropped, only the total moves
          rep.drop = 1'b1;
          dropped++;
        end
      end
      rep.pairs = fill_level[PAIRS_W-1:0];
      rep.total = frame_count;
      owed_reports = {owed_reports, rep};
    endfunction

    function void compare_field(string name, logic [COUNT_W-1:0] want,
                                logic [COUNT_W-1:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        error_count++;
      end
    endfunction

    // Result strobe from the block: compare with the oldest owed report
    function void check_report(logic [SLOT_W-1:0] slot, logic [COUNT_W-1:0] hits,
                               logic is_new, logic drop, logic [PAIRS_W-1:0] pairs,
                               logic [COUNT_W-1:0] total);
      frame_report_t rep;
      reports_seen++;
      if (owed_reports.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual slot %0h hits %0h",
                 $time, slot, hits);
        error_count++;
        return;
      end
      rep = owed_reports.pop_front();
      compare_field("slot_index", COUNT_W'(rep.slot), COUNT_W'(slot));
      compare_field("hit_count", rep.hits, hits);
      compare_field("is_new_entry", COUNT_W'(rep.is_new), COUNT_W'(is_new));
      compare_field("table_full_drop", COUNT_W'(rep.drop), COUNT_W'(drop));
      compare_field("distinct_pairs", COUNT_W'(rep.pairs), COUNT_W'(pairs));
      compare_field("total_frames", rep.total, total);
    endfunction

    function int unsigned pending();
      return owed_reports.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [FRAME_ID_W-1:0] in_frame_id;
  logic [CHAN_W-1:0]     in_bus_channel;
  logic                  out_valid;
  logic [SLOT_W-1:0]     out_slot_index;
  logic [COUNT_W-1:0]    out_hit_count;
  logic                  out_is_new_entry;
  logic                  out_table_full_drop;
  logic [PAIRS_W-1:0]    out_distinct_pairs;
  logic [COUNT_W-1:0]    out_total_frames;

  frame_histogram histo = new();

  logic [FRAME_ID_W-1:0] known_ids[$];
  logic [CHAN_W-1:0]     known_chans[$];
  int unsigned           burst_left;
  int unsigned           idle_cycles;

  can_id_hit_counter #(
    .TABLE_ENTRIES(TABLE_DEPTH)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_frame_id        (in_frame_id),
    .in_bus_channel     (in_bus_channel),
    .out_valid          (out_valid),
    .out_slot_index     (out_slot_index),
    .out_hit_count      (out_hit_count),
    .out_is_new_entry   (out_is_new_entry),
    .out_table_full_drop(out_table_full_drop),
    .out_distinct_pairs (out_distinct_pairs),
    .out_total_frames   (out_total_frames)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Input handshake: note every accepted frame
  always @(posedge clk) begin
    if (rst_n && start && !busy) histo.record_frame(in_frame_id, in_bus_channel);
  end

  // Result strobe: check against the prediction
  always @(posedge clk) begin
    if (rst_n && out_valid)
      histo.check_report(out_slot_index, out_hit_count, out_is_new_entry,
                         out_table_full_drop, out_distinct_pairs, out_total_frames);
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no handshake for %0d cycles", $time, idle_cycles);
        $display("can_id_hit_counter verification failed");
        $finish;
      end
    end
  end

  // Present one frame after a random gap and hold it until taken
  task automatic drive_frame(logic [FRAME_ID_W-1:0] ident, logic [CHAN_W-1:0] chan);
    int unsigned gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(5, 20);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_frame_id    <= ident;
    in_bus_channel <= chan;
    known_ids   = {known_ids, ident};
    known_chans = {known_chans, chan};
    do @(posedge clk); while (busy);
  endtask

  initial begin
    int unsigned pick;
    int unsigned idx;
    int unsigned after_full;
    int unsigned drawn;
    logic [FRAME_ID_W-1:0] ident;
    logic [CHAN_W-1:0]     chan;

    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_frame_id    <= '0;
    in_bus_channel <= '0;
    burst_left     = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, hits, same id on other channels, bit patterns
    drive_frame('0, '0);
    drive_frame('0, '0);
    drive_frame({FRAME_ID_W{1'b1}}, {CHAN_W{1'b1}});
    drive_frame({FRAME_ID_W{1'b1}}, {CHAN_W{1'b1}});
    drive_frame('0, {CHAN_W{1'b1}});
    drive_frame({FRAME_ID_W{1'b1}}, '0);
    drive_frame(29'h000007FF, 8'h01);
    drive_frame(29'h000007FF, 8'h02);
    drive_frame(29'h15555555, 8'hAA);
    drive_frame(29'h0AAAAAAA, 8'h55);
    drive_frame(29'h0AAAAAAA, 8'hAA);
    drive_frame(29'h15555555, 8'h55);
    drive_frame('0, '0);
    drive_frame(29'h0AAAAAAA, 8'h55);
    drive_frame(29'h000007FF, 8'h01);
    // back-to-back repeats of one pair
    burst_left = 4;
    drive_frame(29'h00000123, 8'h07);
    drive_frame(29'h00000123, 8'h07);
    drive_frame(29'h00000123, 8'h07);
    drive_frame(29'h00000124, 8'h07);

    // Random: fill the table with fresh pairs mixed with repeats, then keep going
    // on the full table so that repeats still hit and fresh pairs get dropped
    after_full = 0;
    drawn = 0;
    while (after_full < 70 && drawn < 1000) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        if ($urandom_range(0, 2) == 0) ident = FRAME_ID_W'($urandom_range(0, 2047));
        else ident = FRAME_ID_W'($urandom);
        chan = CHAN_W'($urandom_range(0, 255));
      end else if (pick < 75) begin
        idx   = $urandom_range(0, known_ids.size() - 1);
        ident = known_ids[idx];
        chan  = CHAN_W'($urandom_range(0, 255));
      end else begin
        idx   = $urandom_range(0, known_ids.size() - 1);
        ident = known_ids[idx];
        chan  = known_chans[idx];
      end
      drive_frame(ident, chan);
      drawn++;
      if (histo.fill_level == TABLE_DEPTH) after_full++;
    end
    start <= 1'b0;

    // Drain, then watch a while longer for stray strobes
    while (histo.pending() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 20) @(posedge clk);

    $display("Run covered %0d frames: %0d new pairs, %0d repeat hits, %0d dropped when full",
             histo.new_pairs + histo.repeat_hits + histo.dropped, histo.new_pairs,
             histo.repeat_hits, histo.dropped);
    $display("Table reached %0d of %0d entries; %0d results checked",
             histo.fill_level, TABLE_DEPTH, histo.reports_seen);
    if (histo.error_count == 0) begin
      $display("can_id_hit_counter verification clean");
    end else begin
      $display("can_id_hit_counter verification failed");
    end
    $finish;
  end
endmodule
